// ----- hdl/rsi_pkg.sv -----
`timescale 1ns / 1ps

package rsi_pkg;

    // Defaults for the top-level parameters
    localparam int DATA_W_DEF = 32;
    localparam int FRAC_W_DEF = 16;

    // Fixed register widths
    localparam int LVL_W  = 31;
    localparam int PROD_W = 2 * LVL_W;
    localparam int K2M_W  = LVL_W + 1;
    localparam int IDX_W  = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MIN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_KNEE = 2'd1;
    localparam logic [IDX_W-1:0] REG_SOFT = 2'd2;

    // Reset values
    localparam logic [LVL_W-1:0]  MIN_RST  = 31'd65536;
    localparam logic [LVL_W-1:0]  KNEE_RST = 31'd131072;
    localparam logic [PROD_W-1:0] THR2_RST = PROD_W'(MIN_RST) * PROD_W'(MIN_RST);
    localparam logic [PROD_W-1:0] KK_RST   = PROD_W'(KNEE_RST) * PROD_W'(KNEE_RST);
    localparam logic [K2M_W-1:0]  K2M_RST  = K2M_W'({KNEE_RST, 1'b0}) - K2M_W'(MIN_RST);

    // Effective configuration handed to the datapath
    typedef struct packed {
        logic [LVL_W-1:0]  m;     // minimum level, never zero
        logic [LVL_W-1:0]  k;     // knee level, never below m
        logic              soft_knee;
        logic [LVL_W-1:0]  thr;   // active threshold
        logic [PROD_W-1:0] thr2;  // thr squared
        logic [PROD_W-1:0] kk;    // k squared
        logic [K2M_W-1:0]  k2m;   // 2k - m
    } cfg_t;

endpackage

// ----- hdl/regularized_spectral_inverse.sv -----
`timescale 1ns / 1ps

// Gain-limited inverse of one spectrum bin per transaction. A complex bin z
// gives conj(z)/|z|^2, a real-only (DC or Nyquist) bin x gives 1/x; below the
// minimum level (hard mode) or the knee level (soft mode) the gain is limited
// and a complex bin keeps its phase as re/a, im/a. All values are signed
// Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS and each result part saturates. The block
// takes one bin every clock cycle while the skid entry is empty. The pipeline
// holds three bit-per-stage units in series: the magnitude square root
// (DATA_WIDTH stages), the gain divider (2*FRAC_BITS+1 stages) and the final
// pair of dividers (DATA_WIDTH stages). An output register plus one skid
// entry sit behind the pipeline, so back-pressure on inv_ready reaches
// bin_ready only after a result is parked. Configuration writes take effect
// after the effective and derived level registers and must happen while no
// transaction is in flight.
module regularized_spectral_inverse
#(
    parameter int DATA_WIDTH = rsi_pkg::DATA_W_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_W_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsi_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rsi_pkg::LVL_W-1:0]     cfg_data,
    input  logic                          bin_valid,
    output logic                          bin_ready,
    input  logic signed [DATA_WIDTH-1:0]  bin_re,
    input  logic signed [DATA_WIDTH-1:0]  bin_im,
    input  logic                          real_only,
    output logic                          inv_valid,
    input  logic                          inv_ready,
    output logic signed [DATA_WIDTH-1:0]  inv_re,
    output logic signed [DATA_WIDTH-1:0]  inv_im,
    output logic                          limited,
    output logic                          saturated
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LW   = rsi_pkg::LVL_W;
    localparam int PW   = rsi_pkg::PROD_W;
    localparam int KW   = rsi_pkg::K2M_W;
    localparam int RCW  = ((W > LW) ? W : LW) + 1;        // signed real compare
    localparam int SCW  = (2 * W > PW) ? 2 * W : PW;      // power compare
    localparam int GNW  = ((KW > W) ? KW : W) + 2;        // gain numerator
    localparam int AMW  = W + LW;                         // a * m
    localparam int GDW  = ((PW > AMW) ? PW : AMW) + 1;    // gain denominator
    localparam int GQW  = 2 * F + 1;                      // gain, up to 2^(2F)
    localparam int FNW  = GQW + W;                        // final numerator
    localparam int FDW  = 2 * W;                          // final denominator
    localparam int EW   = ((GQW > W) ? GQW : W) + 1;      // clamp compare width

    typedef struct packed {
        logic [W-1:0] re;
        logic [W-1:0] ure;
        logic [W-1:0] uim;
        logic         nr;     // re negative
        logic         ni;     // im positive, so -im negative
        logic         ro;
    } in_t;

    typedef struct packed {
        logic           ro;
        logic           lim;
        logic           zero;
        logic           nr;
        logic           ni;
        logic [W-1:0]   ure;
        logic [W-1:0]   uim;
        logic [2*W-1:0] s;
    } sq_side_t;

    typedef struct packed {
        sq_side_t     b;
        logic [W-1:0] a;
    } g_side_t;

    typedef struct packed {
        logic           ro;
        logic           lim;
        logic           zero;
        logic           nr;
        logic [GQW-1:0] g;
    } f_side_t;

    typedef struct packed {
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic         lim;
        logic         sat;
    } res_t;

    rsi_pkg::cfg_t cfg;

    rsi_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // Global advance: the whole pipeline holds while the skid entry is full
    logic en;
    logic out_v_reg;
    logic skid_v_reg;

    assign en        = !skid_v_reg;
    assign bin_ready = en;

    // Stage A: register the bin, split sign and magnitude
    logic a_v_reg;
    in_t  a_reg;
    in_t  a_next;

    assign a_next.re  = bin_re;
    assign a_next.ure = bin_re[W-1] ? W'(-bin_re) : W'(bin_re);
    assign a_next.uim = bin_im[W-1] ? W'(-bin_im) : W'(bin_im);
    assign a_next.nr  = bin_re[W-1];
    assign a_next.ni  = !bin_im[W-1] && (bin_im != '0);
    assign a_next.ro  = real_only;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= bin_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_reg <= a_next;
    end

    // Stage B: squares of both parts
    logic           b_v_reg;
    in_t            b_reg;
    logic [2*W-1:0] b_sqre_reg;
    logic [2*W-1:0] b_sqim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg      <= a_reg;
            b_sqre_reg <= (2 * W)'(a_reg.ure) * (2 * W)'(a_reg.ure);
            b_sqim_reg <= (2 * W)'(a_reg.uim) * (2 * W)'(a_reg.uim);
        end
    end

    // Power, threshold decisions, then into the square root
    logic [2*W-1:0]        s_next;
    logic signed [RCW-1:0] re_x;
    logic signed [RCW-1:0] thr_x;
    logic                  lim_r;
    logic                  lim_c;
    sq_side_t              sq_side_next;

    assign s_next = b_sqre_reg + b_sqim_reg;
    assign re_x   = RCW'($signed(b_reg.re));
    assign thr_x  = $signed(RCW'(cfg.thr));
    assign lim_r  = re_x < thr_x;
    assign lim_c  = SCW'(s_next) < SCW'(cfg.thr2);

    assign sq_side_next.ro   = b_reg.ro;
    assign sq_side_next.lim  = b_reg.ro ? lim_r : lim_c;
    assign sq_side_next.zero = (s_next == '0);
    assign sq_side_next.nr   = b_reg.nr;
    assign sq_side_next.ni   = b_reg.ni;
    assign sq_side_next.ure  = b_reg.ure;
    assign sq_side_next.uim  = b_reg.uim;
    assign sq_side_next.s    = s_next;

    logic                         q_v;
    logic [W-1:0]                 q_root;
    logic [$bits(sq_side_t)-1:0]  q_side_bits;
    sq_side_t                     q_sd;

    rsi_isqrt
    #(
        .RW ($bits(q_root)),
        .SW ($bits(sq_side_t))
    )
    u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (b_v_reg),
        .rad      (s_next),
        .in_side  (sq_side_next),
        .out_v    (q_v),
        .root     (q_root),
        .out_side (q_side_bits)
    );

    assign q_sd = sq_side_t'(q_side_bits);

    // Stage D: a * m, where a is the magnitude of the real value for a real-only bin
    logic           d_v_reg;
    g_side_t        d_side_reg;
    logic [AMW-1:0] d_am_reg;
    logic [W-1:0]   d_av;

    assign d_av = q_sd.ro ? q_sd.ure : q_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (en)
            d_v_reg <= q_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg.b <= q_sd;
            d_side_reg.a <= q_root;
            d_am_reg     <= AMW'(d_av) * AMW'(cfg.m);
        end
    end

    // Stage E: pick the gain quotient. Hard limit and zero magnitude use
    // 1/m, the soft knee uses (2k-m-a)/(k^2-a*m), an unlimited real bin 1/x.
    logic           e_v_reg;
    g_side_t        e_side_reg;
    logic [GNW-1:0] e_gnum_reg;
    logic [GDW-1:0] e_gden_reg;
    logic [GNW-1:0] gnum_next;
    logic [GDW-1:0] gden_next;
    logic [W-1:0]   e_av;
    logic           e_neg;
    logic           soft_g;
    logic           real_n;

    assign e_av   = d_side_reg.b.ro ? d_side_reg.b.ure : d_side_reg.a;
    assign e_neg  = d_side_reg.b.ro && d_side_reg.b.nr;
    assign soft_g = d_side_reg.b.lim && cfg.soft_knee
                    && (d_side_reg.b.ro || !d_side_reg.b.zero);
    assign real_n = d_side_reg.b.ro && !d_side_reg.b.lim;

    always_comb
    begin
        gnum_next = GNW'(1);
        gden_next = GDW'(cfg.m);
        if (soft_g)
        begin
            gnum_next = e_neg ? (GNW'(cfg.k2m) + GNW'(e_av)) : (GNW'(cfg.k2m) - GNW'(e_av));
            gden_next = e_neg ? (GDW'(cfg.kk) + GDW'(d_am_reg))
                              : (GDW'(cfg.kk) - GDW'(d_am_reg));
        end
        else if (real_n)
        begin
            gden_next = GDW'(d_side_reg.b.ure);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (en)
            e_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg <= d_side_reg;
            e_gnum_reg <= gnum_next;
            e_gden_reg <= gden_next;
        end
    end

    // Gain divider: g = floor(gnum * 2^2F / gden)
    logic                        g_v;
    logic [GQW-1:0]              g_q;
    logic                        g_ovf;
    logic [$bits(g_side_t)-1:0]  g_side_bits;

    rsi_div
    #(
        .NW (GNW + 2 * F),
        .DW (GDW),
        .QW (GQW),
        .SW ($bits(g_side_t))
    )
    u_gain_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (e_v_reg),
        .num      ({e_gnum_reg, {(2 * F){1'b0}}}),
        .den      (e_gden_reg),
        .in_side  (e_side_reg),
        .out_v    (g_v),
        .quo      (g_q),
        .ovf      (g_ovf),
        .out_side (g_side_bits)
    );

    // Stage F: scale both magnitudes by the gain
    logic           f_v_reg;
    g_side_t        f_side_reg;
    logic [GQW-1:0] f_g_reg;
    logic [FNW-1:0] f_pr_reg;
    logic [FNW-1:0] f_pi_reg;
    logic [GQW-1:0] g_val;
    g_side_t        g_sd;

    assign g_sd  = g_side_t'(g_side_bits);
    assign g_val = g_ovf ? '1 : g_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (en)
            f_v_reg <= g_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg <= g_sd;
            f_g_reg    <= g_val;
            f_pr_reg   <= FNW'(g_val) * FNW'(g_sd.b.ure);
            f_pi_reg   <= FNW'(g_val) * FNW'(g_sd.b.uim);
        end
    end

    // Final quotients: limited complex bins divide g*|part| by a, normal
    // complex bins divide |part| * 2^2F by the power
    logic           use_q;
    logic [FNW-1:0] fr_num;
    logic [FNW-1:0] fi_num;
    logic [FDW-1:0] f_den;
    f_side_t        f_side_next;

    assign use_q  = !f_side_reg.b.ro && f_side_reg.b.lim && !f_side_reg.b.zero;
    assign fr_num = use_q ? f_pr_reg : FNW'({f_side_reg.b.ure, {(2 * F){1'b0}}});
    assign fi_num = use_q ? f_pi_reg : FNW'({f_side_reg.b.uim, {(2 * F){1'b0}}});
    assign f_den  = use_q ? FDW'(f_side_reg.a) : f_side_reg.b.s;

    assign f_side_next.ro   = f_side_reg.b.ro;
    assign f_side_next.lim  = f_side_reg.b.lim;
    assign f_side_next.zero = f_side_reg.b.zero;
    assign f_side_next.nr   = f_side_reg.b.nr;
    assign f_side_next.g    = f_g_reg;

    logic                        fr_v;
    logic [W-1:0]                fr_q;
    logic                        fr_ovf;
    logic [$bits(f_side_t)-1:0]  fr_side_bits;
    logic                        fi_v;
    logic [W-1:0]                fi_q;
    logic                        fi_ovf;
    logic                        fi_ni;

    rsi_div
    #(
        .NW (FNW),
        .DW (FDW),
        .QW (W),
        .SW ($bits(f_side_t))
    )
    u_re_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (f_v_reg),
        .num      (fr_num),
        .den      (f_den),
        .in_side  (f_side_next),
        .out_v    (fr_v),
        .quo      (fr_q),
        .ovf      (fr_ovf),
        .out_side (fr_side_bits)
    );

    rsi_div
    #(
        .NW (FNW),
        .DW (FDW),
        .QW (W),
        .SW (1)
    )
    u_im_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (f_v_reg),
        .num      (fi_num),
        .den      (f_den),
        .in_side  (f_side_reg.b.ni),
        .out_v    (fi_v),
        .quo      (fi_q),
        .ovf      (fi_ovf),
        .out_side (fi_ni)
    );

    // Clamp one part to the signed range; returns {sat, value}
    function automatic logic [W:0] clamp_part
    (
        input logic [EW-1:0] mag,
        input logic          ovf,
        input logic          neg
    );
        logic [EW-1:0] lim;
        logic          sat;
        logic [W-1:0]  m;
        lim = neg ? EW'({1'b1, {(W - 1){1'b0}}}) : EW'({1'b0, {(W - 1){1'b1}}});
        sat = ovf || (mag > lim);
        m   = sat ? lim[W-1:0] : mag[W-1:0];
        return {sat, neg ? (W'(0) - m) : m};
    endfunction

    f_side_t     o_sd;
    logic        use_g;
    logic [W:0]  cr;
    logic [W:0]  ci;
    res_t        res_next;
    logic        pipe_fire;

    assign o_sd  = f_side_t'(fr_side_bits);
    assign use_g = o_sd.ro || o_sd.zero;

    // Real-only and zero-magnitude bins carry the gain itself, imaginary zero
    assign cr = clamp_part(use_g ? EW'(o_sd.g) : EW'(fr_q),
                           !use_g && fr_ovf, !use_g && o_sd.nr);
    assign ci = clamp_part(use_g ? '0 : EW'(fi_q),
                           !use_g && fi_ovf, !use_g && fi_ni);

    assign res_next.re  = cr[W-1:0];
    assign res_next.im  = ci[W-1:0];
    assign res_next.lim = o_sd.lim;
    assign res_next.sat = cr[W] || ci[W];

    assign pipe_fire = en && fr_v && fi_v;

    // Output register with one skid entry
    res_t out_reg;
    res_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || inv_ready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= pipe_fire;
            end
        end
        else if (pipe_fire)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || inv_ready)
            out_reg <= skid_v_reg ? skid_reg : res_next;
        else if (pipe_fire)
            skid_reg <= res_next;
    end

    assign inv_valid = out_v_reg;
    assign inv_re    = out_reg.re;
    assign inv_im    = out_reg.im;
    assign limited   = out_reg.lim;
    assign saturated = out_reg.sat;

`ifndef ASSERT_OFF
    // A parked result always has a presented result in front of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry full while output register empty");

    // The skid entry only fills on a stalled output
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !inv_ready))
        else $error("skid entry filled without output stall");

    // Effective levels stay legal: m nonzero, knee at least m
    a_cfg_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.m != '0) && (cfg.k >= cfg.m))
        else $error("effective level configuration out of range");
`endif

endmodule

// ----- hdl/rsi_cfg.sv -----
`timescale 1ns / 1ps

module rsi_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [rsi_pkg::IDX_W-1:0]  index,
    input  logic [rsi_pkg::LVL_W-1:0]  data,
    output rsi_pkg::cfg_t              cfg
);

    localparam int LW = rsi_pkg::LVL_W;
    localparam int PW = rsi_pkg::PROD_W;
    localparam int KW = rsi_pkg::K2M_W;

    logic [LW-1:0] min_reg;
    logic [LW-1:0] knee_reg;
    logic          soft_reg;
    logic [LW-1:0] m_reg;
    logic [LW-1:0] k_reg;
    logic          soft_d_reg;
    logic [LW-1:0] thr_reg;
    logic [PW-1:0] thr2_reg;
    logic [PW-1:0] kk_reg;
    logic [KW-1:0] k2m_reg;

    logic [LW-1:0] m_next;
    logic [LW-1:0] k_next;
    logic [LW-1:0] thr_next;

    // Force a zero minimum to one, lift the knee to the minimum
    assign m_next   = (min_reg == '0) ? LW'(1) : min_reg;
    assign k_next   = (knee_reg < m_next) ? m_next : knee_reg;
    assign thr_next = soft_d_reg ? k_reg : m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= rsi_pkg::MIN_RST;
            knee_reg   <= rsi_pkg::KNEE_RST;
            soft_reg   <= 1'b0;
            m_reg      <= rsi_pkg::MIN_RST;
            k_reg      <= rsi_pkg::KNEE_RST;
            soft_d_reg <= 1'b0;
            thr_reg    <= rsi_pkg::MIN_RST;
            thr2_reg   <= rsi_pkg::THR2_RST;
            kk_reg     <= rsi_pkg::KK_RST;
            k2m_reg    <= rsi_pkg::K2M_RST;
        end
        else
        begin
            if (we)
            begin
                case (index)
                    rsi_pkg::REG_MIN:  min_reg  <= data;
                    rsi_pkg::REG_KNEE: knee_reg <= data;
                    rsi_pkg::REG_SOFT: soft_reg <= data[0];
                    default: ;
                endcase
            end
            m_reg      <= m_next;
            k_reg      <= k_next;
            soft_d_reg <= soft_reg;
            thr_reg    <= thr_next;
            thr2_reg   <= PW'(thr_next) * PW'(thr_next);
            kk_reg     <= PW'(k_reg) * PW'(k_reg);
            k2m_reg    <= KW'({k_reg, 1'b0}) - KW'(m_reg);
        end
    end

    assign cfg.m         = m_reg;
    assign cfg.k         = k_reg;
    assign cfg.soft_knee = soft_d_reg;
    assign cfg.thr       = thr_reg;
    assign cfg.thr2      = thr2_reg;
    assign cfg.kk        = kk_reg;
    assign cfg.k2m       = k2m_reg;

endmodule

// ----- hdl/rsi_isqrt.sv -----
`timescale 1ns / 1ps

module rsi_isqrt
#(
    parameter int RW = 32,
    parameter int SW = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_v,
    input  logic [2*RW-1:0] rad,
    input  logic [SW-1:0]   in_side,
    output logic            out_v,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   out_side
);

    localparam int VW = 2 * RW;

    logic          v_reg    [RW+1];
    logic [VW-1:0] vsh_reg  [RW];
    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW+1];
    logic [SW-1:0] side_reg [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vsh_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // One root bit per stage: shift in two radicand bits, try root*4+1
    for (genvar i = 0; i < RW; i++)
    begin : g_step
        logic [RW+3:0] rem4;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        assign rem4  = {rem_reg[i], vsh_reg[i][VW-1:VW-2]};
        assign trial = {2'b00, root_reg[i], 2'b01};
        assign ge    = rem4 >= trial;
        assign diff  = rem4 - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i+1] <= {root_reg[i][RW-2:0], ge};
                side_reg[i+1] <= side_reg[i];
            end
        end

        if (i < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? diff[RW+1:0] : rem4[RW+1:0];
                    vsh_reg[i+1] <= {vsh_reg[i][VW-3:0], 2'b00};
                end
            end
        end
    end

    assign out_v    = v_reg[RW];
    assign root     = root_reg[RW];
    assign out_side = side_reg[RW];

endmodule

// ----- hdl/rsi_div.sv -----
`timescale 1ns / 1ps

module rsi_div
#(
    parameter int NW = 66,
    parameter int DW = 64,
    parameter int QW = 33,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_v,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] out_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic          v_reg    [QW+1];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] qn_reg   [QW+1];
    logic [DW-1:0] den_reg  [QW];
    logic          ovf_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    // The quotient overflows QW bits exactly when the upper part reaches the divisor
    assign hi_ext  = CW'(num[NW-1:QW]);
    assign den_ext = CW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= hi_ext[DW-1:0];
            qn_reg[0]   <= num[QW-1:0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= hi_ext >= den_ext;
            side_reg[0] <= in_side;
        end
    end

    // Restoring division, one quotient bit per stage; quotient bits
    // shift into the vacated low end of the dividend word
    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[i], qn_reg[i][QW-1]};
        assign ge    = trial >= {1'b0, den_reg[i]};
        assign diff  = trial - {1'b0, den_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qn_reg[i+1]   <= {qn_reg[i][QW-2:0], ge};
                ovf_reg[i+1]  <= ovf_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    den_reg[i+1] <= den_reg[i];
                end
            end
        end
    end

    assign out_v    = v_reg[QW];
    assign quo      = qn_reg[QW];
    assign ovf      = ovf_reg[QW];
    assign out_side = side_reg[QW];

endmodule
